[rtl/vcr_pkg.sv]
// Package for the voxel cube rasterizer: sizes, constants, payload types, states.
`timescale 1ns / 1ps
package vcr_pkg;

	localparam int IMAGE_WIDTH   = 256;
	localparam int IMAGE_HEIGHT  = 256;
	localparam int FRACTION_BITS = 8;

	localparam int XW = $clog2(IMAGE_WIDTH);
	localparam int YW = $clog2(IMAGE_HEIGHT);
	localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int AW = $clog2(DEPTH);

	localparam int VW = 28;              // projected vertex, signed Qf
	localparam int BW = VW - FRACTION_BITS; // pixel coordinate before clipping
	localparam int MW = 30;              // shared multiplier operand
	localparam int PW = 2 * MW;          // product
	localparam int EW = PW + 2;          // edge accumulator

	localparam longint FX_ONE   = longint'(1) << FRACTION_BITS;
	localparam longint FX_HALF  = longint'(1) << (FRACTION_BITS - 1);
	localparam longint ISO_X_Q  = ((longint'(56756) << FRACTION_BITS) + 32768) >> 16;
	localparam longint AREA_MIN = ((longint'(1) << (2 * FRACTION_BITS)) + 9999) / 10000;
	localparam longint K_RIGHT  = ((longint'(72) << FRACTION_BITS) + 50) / 100;
	localparam longint K_LEFT   = ((longint'(56) << FRACTION_BITS) + 50) / 100;
	localparam longint K_TOP    = ((longint'(100) << FRACTION_BITS) + 50) / 100;
	localparam longint K_SMALL  = ((longint'(95) << FRACTION_BITS) + 50) / 100;
	localparam longint SMALL_LIM = 6 * FX_ONE;

	// gradient: v = (68*(H-1) + 32*y + (H-1)) / (2*(H-1)), stepped per row
	localparam int GDEN = 2 * (IMAGE_HEIGHT - 1);
	localparam int GNUM0 = 69 * (IMAGE_HEIGHT - 1);
	localparam int GV0 = GNUM0 / GDEN;
	localparam int GR0 = GNUM0 % GDEN;
	localparam int GSQ = 32 / GDEN;
	localparam int GSR = 32 % GDEN;
	localparam int GRW = $clog2(GDEN) + 1;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_DRAW  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic [1:0] CFG_SCALE = 2'd0;
	localparam logic [1:0] CFG_OFFX  = 2'd1;
	localparam logic [1:0] CFG_OFFY  = 2'd2;

	localparam logic [1:0] FACE_RIGHT = 2'd0;
	localparam logic [1:0] FACE_LEFT  = 2'd1;
	localparam logic [1:0] FACE_TOP   = 2'd2;

	typedef struct packed {
		action_t     action;
		logic [11:0] voxel_x;
		logic [7:0]  voxel_y;
		logic [7:0]  voxel_z;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  pixel_column;
		logic [7:0]  pixel_row;
	} cmd_t;

	typedef struct packed {
		logic [1:0] reply_kind;
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} reply_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_RD, ST_SHADE, ST_PROJ, ST_DOT,
		ST_BOX, ST_MUL, ST_CHECK, ST_SCAN, ST_DONE
	} state_t;

	// corner offsets {dx, dy, dz} of each face, corners in winding order
	function automatic logic [2:0] face_corner(input logic [1:0] face, input logic [1:0] idx);
		logic [2:0] r;
		r = 3'b000;
		unique case (face)
			FACE_RIGHT: begin
				unique case (idx)
					2'd0: r = 3'b100;
					2'd1: r = 3'b110;
					2'd2: r = 3'b111;
					default: r = 3'b101;
				endcase
			end
			FACE_LEFT: begin
				unique case (idx)
					2'd0: r = 3'b010;
					2'd1: r = 3'b110;
					2'd2: r = 3'b111;
					default: r = 3'b011;
				endcase
			end
			default: begin
				unique case (idx)
					2'd0: r = 3'b001;
					2'd1: r = 3'b101;
					2'd2: r = 3'b111;
					default: r = 3'b011;
				endcase
			end
		endcase
		return r;
	endfunction

	function automatic logic [7:0] shade_ch(input logic [7:0] c, input logic [8:0] k);
		logic [17:0] v;
		v = (18'(c) * 18'(k) + 18'(FX_HALF)) >> FRACTION_BITS;
		return (v > 18'd255) ? 8'd255 : v[7:0];
	endfunction

endpackage

[rtl/voxel_cube_rasterizer.sv]
// Voxel cube rasterizer: command sequencer, shared multiplier, edge scan, frame store.
// Clear writes every pixel; read fetches one; unused action only replies; small-scale
// draw plots one pixel; full draw: 3 faces x (4x4 projection + 2 triangle scans).
// One command at a time; busy stays high until its reply strobe (done), one cycle.
// The frame store is written one pixel a cycle; the edge scan visits one pixel a cycle.
// Reset (arst_n low) resets control and config; the frame store is undefined until cleared.
`timescale 1ns / 1ps
module voxel_cube_rasterizer import vcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        done,
	output reply_t      reply,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam logic signed [BW-1:0] XMAX = BW'(IMAGE_WIDTH - 1);
	localparam logic signed [BW-1:0] YMAX = BW'(IMAGE_HEIGHT - 1);

	state_t state_q, state_d;

	cmd_t                cmd_q;
	logic [12:0]         scale_q;
	logic signed [23:0]  offx_q, offy_q;
	logic                small_q;
	logic [1:0]          face_q, vi_q, ps_q;
	logic                tri_q;
	logic signed [VW-1:0] vx_q [4];
	logic signed [VW-1:0] vy_q [4];
	logic [23:0]         rgb_q;
	logic [XW-1:0]       bx0_q, bx1_q, px_q;
	logic [YW-1:0]       by0_q, by1_q, py_q;
	logic                empty_q;
	logic signed [MW-1:0] dxe_q [3];
	logic signed [MW-1:0] dye_q [3];
	logic signed [EW-1:0] acc_q [4];
	logic signed [EW-1:0] e_q [3];
	logic [3:0]          mstep_q;
	logic signed [PW-1:0] prod_q;
	logic [XW-1:0]       cx_q;
	logic [YW-1:0]       cy_q;
	logic [7:0]          gv_q;
	logic [GRW-1:0]      grem_q;
	logic [23:0]         rd_q;
	logic [23:0]         mem [DEPTH];

	// combinational
	logic signed [MW-1:0] mul_a, mul_b;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [23:0]          mem_wdata;
	logic signed [VW-1:0] ax, ay, bx, by, tcx, tcy;
	logic signed [VW-1:0] eux [3], euy [3], evx [3], evy [3];
	logic signed [VW-1:0] mnx, mxx, mny, mxy;
	logic signed [BW-1:0] fx0, fx1, fy0, fy1;
	logic signed [MW-1:0] cx0, cy0;
	logic                 covered, last_px, last_py, tri_last, accept;
	logic [2:0]           corner;
	logic [13:0]          x2, y2, z2;
	logic signed [MW-1:0] dxy, sxy;
	logic signed [PW-1:0] rx, ry;
	logic signed [BW-1:0] dot_x, dot_y;
	logic                 dot_in;
	logic signed [EW-1:0] area;
	logic                 area_small;
	logic [8:0]           shade_k;
	logic                 rd_in;

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	// vertex selection for the current triangle
	always_comb begin
		ax = vx_q[0];
		ay = vy_q[0];
		bx = tri_q ? vx_q[2] : vx_q[1];
		by = tri_q ? vy_q[2] : vy_q[1];
		tcx = tri_q ? vx_q[3] : vx_q[2];
		tcy = tri_q ? vy_q[3] : vy_q[2];
		eux[0] = ax;  euy[0] = ay;  evx[0] = bx;  evy[0] = by;
		eux[1] = bx;  euy[1] = by;  evx[1] = tcx; evy[1] = tcy;
		eux[2] = tcx; euy[2] = tcy; evx[2] = ax;  evy[2] = ay;
		mnx = (ax < bx) ? ax : bx;
		mnx = (mnx < tcx) ? mnx : tcx;
		mxx = (ax > bx) ? ax : bx;
		mxx = (mxx > tcx) ? mxx : tcx;
		mny = (ay < by) ? ay : by;
		mny = (mny < tcy) ? mny : tcy;
		mxy = (ay > by) ? ay : by;
		mxy = (mxy > tcy) ? mxy : tcy;
		fx0 = BW'(mnx >>> FRACTION_BITS);
		fx1 = BW'((mxx + VW'(FX_ONE - 1)) >>> FRACTION_BITS);
		fy0 = BW'(mny >>> FRACTION_BITS);
		fy1 = BW'((mxy + VW'(FX_ONE - 1)) >>> FRACTION_BITS);
		cx0 = $signed(MW'({bx0_q, FRACTION_BITS'(FX_HALF)}));
		cy0 = $signed(MW'({by0_q, FRACTION_BITS'(FX_HALF)}));
	end

	// vertex coordinates in half voxel units
	always_comb begin
		corner = face_corner(face_q, vi_q);
		if (small_q) begin
			x2 = {1'b0, cmd_q.voxel_x, 1'b1};
			y2 = {5'd0, cmd_q.voxel_y, 1'b1};
			z2 = {5'd0, cmd_q.voxel_z, 1'b1};
		end else begin
			x2 = {1'b0, cmd_q.voxel_x, 1'b0} + {12'd0, corner[2], 1'b0};
			y2 = {5'd0, cmd_q.voxel_y, 1'b0} + {12'd0, corner[1], 1'b0};
			z2 = {5'd0, cmd_q.voxel_z, 1'b0} + {12'd0, corner[0], 1'b0};
		end
		dxy = MW'(signed'({1'b0, x2})) - MW'(signed'({1'b0, y2}));
		sxy = MW'(signed'({1'b0, x2})) + MW'(signed'({1'b0, y2}))
			- (MW'(signed'({1'b0, z2})) <<< 1);
		rx = (prod_q + PW'(FX_ONE)) >>> (FRACTION_BITS + 1);
		ry = (prod_q + PW'(2)) >>> 2;
	end

	// single pixel for small scale, rounded half away from zero
	always_comb begin
		if (vx_q[0] >= 0)
			dot_x = BW'((vx_q[0] + VW'(FX_HALF)) >>> FRACTION_BITS);
		else
			dot_x = -BW'((-vx_q[0] + VW'(FX_HALF)) >>> FRACTION_BITS);
		if (vy_q[0] >= 0)
			dot_y = BW'((vy_q[0] + VW'(FX_HALF)) >>> FRACTION_BITS);
		else
			dot_y = -BW'((-vy_q[0] + VW'(FX_HALF)) >>> FRACTION_BITS);
		dot_in = (dot_x >= 0) && (dot_x <= XMAX) && (dot_y >= 0) && (dot_y <= YMAX);
	end

	always_comb begin
		area = acc_q[0];
		area_small = (area > -EW'(AREA_MIN)) && (area < EW'(AREA_MIN));
		covered = ((e_q[0] >= 0) && (e_q[1] >= 0) && (e_q[2] >= 0))
			|| ((e_q[0] <= 0) && (e_q[1] <= 0) && (e_q[2] <= 0));
		last_px = (px_q == bx1_q);
		last_py = (py_q == by1_q);
		tri_last = tri_q && (face_q == FACE_TOP);
		rd_in = (32'(cmd_q.pixel_column) < IMAGE_WIDTH) && (32'(cmd_q.pixel_row) < IMAGE_HEIGHT);
		if (small_q)
			shade_k = 9'(K_SMALL);
		else begin
			unique case (face_q)
				FACE_RIGHT: shade_k = 9'(K_RIGHT);
				FACE_LEFT:  shade_k = 9'(K_LEFT);
				default:    shade_k = 9'(K_TOP);
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.action)
						ACT_CLEAR: state_d = ST_CLEAR;
						ACT_DRAW:  state_d = ST_SHADE;
						ACT_READ:  state_d = ST_RD;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (32'(cx_q) == IMAGE_WIDTH - 1 && 32'(cy_q) == IMAGE_HEIGHT - 1)
					state_d = ST_DONE;
			end
			ST_RD: state_d = ST_DONE;
			ST_SHADE: state_d = ST_PROJ;
			ST_PROJ: begin
				if (ps_q == 2'd3) begin
					if (small_q)
						state_d = ST_DOT;
					else if (vi_q == 2'd3)
						state_d = ST_BOX;
				end
			end
			ST_DOT: state_d = ST_DONE;
			ST_BOX: state_d = ST_MUL;
			ST_MUL: begin
				if (mstep_q == 4'd8)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (empty_q || area_small)
					state_d = tri_last ? ST_DONE : (tri_q ? ST_SHADE : ST_BOX);
				else
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (last_px && last_py)
					state_d = tri_last ? ST_DONE : (tri_q ? ST_SHADE : ST_BOX);
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: multiplier operands and frame store port
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = rgb_q;
		mem_raddr = AW'(32'(cmd_q.pixel_row) * IMAGE_WIDTH + 32'(cmd_q.pixel_column));
		unique case (state_q)
			ST_PROJ: begin
				unique case (ps_q)
					2'd0: begin
						mul_a = dxy;
						mul_b = MW'(ISO_X_Q);
					end
					2'd1: begin
						mul_a = MW'(prod_q);
						mul_b = MW'({1'b0, scale_q});
					end
					2'd2: begin
						mul_a = sxy;
						mul_b = MW'({1'b0, scale_q});
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			ST_MUL: begin
				priority if (mstep_q == 4'd0) begin
					mul_a = MW'(tcx) - MW'(ax);
					mul_b = dye_q[0];
				end else if (mstep_q == 4'd1) begin
					mul_a = MW'(tcy) - MW'(ay);
					mul_b = dxe_q[0];
				end else if (mstep_q < 4'd8) begin
					if (!mstep_q[0]) begin
						mul_a = cx0 - MW'(eux[2'(mstep_q[2:1] - 2'd1)]);
						mul_b = dye_q[2'(mstep_q[2:1] - 2'd1)];
					end else begin
						mul_a = cy0 - MW'(euy[2'(mstep_q[2:1] - 2'd1)]);
						mul_b = dxe_q[2'(mstep_q[2:1] - 2'd1)];
					end
				end else begin
					mul_a = '0;
					mul_b = '0;
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = AW'(32'(cy_q) * IMAGE_WIDTH + 32'(cx_q));
				mem_wdata = {gv_q, gv_q + 8'd2, gv_q + 8'd7};
			end
			ST_SCAN: begin
				mem_we = covered;
				mem_waddr = AW'(32'(py_q) * IMAGE_WIDTH + 32'(px_q));
			end
			ST_DOT: begin
				mem_we = dot_in;
				mem_waddr = AW'(32'(YW'(dot_y)) * IMAGE_WIDTH + 32'(XW'(dot_x)));
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// frame store
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (state_q == ST_RD)
			rd_q <= mem[mem_raddr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scale_q <= 13'(FX_ONE);
			offx_q <= '0;
			offy_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= (state_q == ST_DONE);
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_SCALE: scale_q <= cfg_data[12:0];
					CFG_OFFX:  offx_q <= $signed(cfg_data);
					CFG_OFFY:  offy_q <= $signed(cfg_data);
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q <= cmd;
					small_q <= (16'(scale_q) * 16'd5) < 16'(SMALL_LIM);
					face_q <= FACE_RIGHT;
					tri_q <= 1'b0;
					cx_q <= '0;
					cy_q <= '0;
					gv_q <= 8'(GV0);
					grem_q <= GRW'(GR0);
				end
			end
			ST_CLEAR: begin
				if (32'(cx_q) == IMAGE_WIDTH - 1) begin
					cx_q <= '0;
					cy_q <= cy_q + 1'b1;
					if (grem_q + GRW'(GSR) >= GRW'(GDEN)) begin
						grem_q <= grem_q + GRW'(GSR) - GRW'(GDEN);
						gv_q <= gv_q + 8'(GSQ) + 8'd1;
					end else begin
						grem_q <= grem_q + GRW'(GSR);
						gv_q <= gv_q + 8'(GSQ);
					end
				end else begin
					cx_q <= cx_q + 1'b1;
				end
			end
			ST_SHADE: begin
				rgb_q <= {shade_ch(cmd_q.red, shade_k), shade_ch(cmd_q.green, shade_k),
					shade_ch(cmd_q.blue, shade_k)};
				vi_q <= '0;
				ps_q <= '0;
				tri_q <= 1'b0;
			end
			ST_PROJ: begin
				ps_q <= ps_q + 1'b1;
				if (ps_q == 2'd2)
					vx_q[vi_q] <= VW'(rx) + VW'(offx_q);
				if (ps_q == 2'd3) begin
					vy_q[vi_q] <= VW'(ry) + VW'(offy_q);
					vi_q <= vi_q + 1'b1;
				end
			end
			ST_BOX: begin
				empty_q <= (fx0 > XMAX) || (fx1 < 0) || (fy0 > YMAX) || (fy1 < 0);
				bx0_q <= (fx0 < 0) ? '0 : XW'(fx0);
				bx1_q <= (fx1 > XMAX) ? XW'(IMAGE_WIDTH - 1) : XW'(fx1);
				by0_q <= (fy0 < 0) ? '0 : YW'(fy0);
				by1_q <= (fy1 > YMAX) ? YW'(IMAGE_HEIGHT - 1) : YW'(fy1);
				for (int j = 0; j < 3; j++) begin
					dxe_q[j] <= MW'(evx[j]) - MW'(eux[j]);
					dye_q[j] <= MW'(evy[j]) - MW'(euy[j]);
				end
				mstep_q <= '0;
			end
			ST_MUL: begin
				mstep_q <= mstep_q + 1'b1;
				if (mstep_q != 4'd0) begin
					if (mstep_q[0])
						acc_q[2'(mstep_q[3:1])] <= EW'(prod_q);
					else
						acc_q[2'(mstep_q[3:1] - 3'd1)] <= acc_q[2'(mstep_q[3:1] - 3'd1)]
							- EW'(prod_q);
				end
			end
			ST_CHECK: begin
				for (int j = 0; j < 3; j++)
					e_q[j] <= acc_q[j + 1];
				px_q <= bx0_q;
				py_q <= by0_q;
				if (empty_q || area_small) begin
					tri_q <= ~tri_q;
					if (tri_q)
						face_q <= face_q + 1'b1;
				end
			end
			ST_SCAN: begin
				if (last_px) begin
					if (last_py) begin
						tri_q <= ~tri_q;
						if (tri_q)
							face_q <= face_q + 1'b1;
					end else begin
						py_q <= py_q + 1'b1;
						px_q <= bx0_q;
						for (int j = 0; j < 3; j++) begin
							acc_q[j + 1] <= acc_q[j + 1] - (EW'(dxe_q[j]) <<< FRACTION_BITS);
							e_q[j] <= acc_q[j + 1] - (EW'(dxe_q[j]) <<< FRACTION_BITS);
						end
					end
				end else begin
					px_q <= px_q + 1'b1;
					for (int j = 0; j < 3; j++)
						e_q[j] <= e_q[j] + (EW'(dye_q[j]) <<< FRACTION_BITS);
				end
			end
			ST_DONE: begin
				reply.reply_kind <= cmd_q.action;
				if (cmd_q.action == ACT_READ && rd_in) begin
					reply.pixel_red <= rd_q[23:16];
					reply.pixel_green <= rd_q[15:8];
					reply.pixel_blue <= rd_q[7:0];
				end else begin
					reply.pixel_red <= '0;
					reply.pixel_green <= '0;
					reply.pixel_blue <= '0;
				end
			end
			default: ;
		endcase
	end

endmodule

[tb/voxel_cube_rasterizer_tb.sv]
// Self-checking testbench for the voxel cube rasterizer: directed table, then random phases.
`timescale 1ns / 1ps
module voxel_cube_rasterizer_tb;
	import vcr_pkg::*;

	localparam longint CYCLE_LIMIT = 4000000;
	localparam longint ISO_Q    = 222;
	localparam longint MIN_AREA = 7;
	localparam longint SH_RIGHT = 184;
	localparam longint SH_LEFT  = 143;
	localparam longint SH_TOP   = 256;
	localparam longint SH_SMALL = 243;

	typedef struct {
		longint x;
		longint y;
	} vtx_t;

	typedef struct {
		cmd_t   c;
		bit     typed;
		reply_t r;
	} row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        busy;
	cmd_t        cmd       = '0;
	logic        done;
	reply_t      reply;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_data  = '0;

	voxel_cube_rasterizer dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .reply(reply), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// shadow of the frame and registers
	bit [23:0] pix_mem [0:DEPTH-1];
	longint    scl = 256;
	longint    offx = 0;
	longint    offy = 0;
	int        last_col = 0;
	int        last_row = 0;

	reply_t pending_replies[$];
	int     mismatches = 0;
	int     replies_seen = 0;
	longint cycles = 0;
	int     n_clear = 0, n_draw = 0, n_read = 0, n_other = 0, n_phase = 0;

	function automatic longint rnd_sh(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint round_away(longint v);
		if (v >= 0)
			return (v + FX_HALF) >>> FRACTION_BITS;
		return -((-v + FX_HALF) >>> FRACTION_BITS);
	endfunction

	function automatic vtx_t proj(longint x2, longint y2, longint z2);
		vtx_t p;
		p.x = rnd_sh((x2 - y2) * ISO_Q * scl, FRACTION_BITS + 1) + offx;
		p.y = rnd_sh((x2 + y2 - 2 * z2) * scl, 2) + offy;
		return p;
	endfunction

	function automatic longint edge_fn(vtx_t a, vtx_t b, longint px, longint py);
		return (px - a.x) * (b.y - a.y) - (py - a.y) * (b.x - a.x);
	endfunction

	function automatic bit [23:0] shade_rgb(bit [7:0] r, bit [7:0] g, bit [7:0] b, longint k);
		longint v[3];
		bit [23:0] o;
		v[0] = (longint'(r) * k + FX_HALF) >>> FRACTION_BITS;
		v[1] = (longint'(g) * k + FX_HALF) >>> FRACTION_BITS;
		v[2] = (longint'(b) * k + FX_HALF) >>> FRACTION_BITS;
		for (int i = 0; i < 3; i++)
			o[23 - 8 * i -: 8] = (v[i] > 255) ? 8'd255 : v[i][7:0];
		return o;
	endfunction

	function automatic void plot(longint x, longint y, bit [23:0] rgb);
		if (x < 0 || y < 0 || x >= IMAGE_WIDTH || y >= IMAGE_HEIGHT)
			return;
		pix_mem[y * IMAGE_WIDTH + x] = rgb;
	endfunction

	function automatic void fill_triangle(vtx_t a, vtx_t b, vtx_t c, bit [23:0] rgb);
		longint area, x0, x1, y0, y1, cx, cy, e0, e1, e2;
		area = edge_fn(a, b, c.x, c.y);
		if (area > -MIN_AREA && area < MIN_AREA)
			return;
		x0 = (a.x < b.x ? (a.x < c.x ? a.x : c.x) : (b.x < c.x ? b.x : c.x)) >>> FRACTION_BITS;
		y0 = (a.y < b.y ? (a.y < c.y ? a.y : c.y) : (b.y < c.y ? b.y : c.y)) >>> FRACTION_BITS;
		x1 = ((a.x > b.x ? (a.x > c.x ? a.x : c.x) : (b.x > c.x ? b.x : c.x))
			+ FX_ONE - 1) >>> FRACTION_BITS;
		y1 = ((a.y > b.y ? (a.y > c.y ? a.y : c.y) : (b.y > c.y ? b.y : c.y))
			+ FX_ONE - 1) >>> FRACTION_BITS;
		if (x0 < 0) x0 = 0;
		if (y0 < 0) y0 = 0;
		if (x1 > IMAGE_WIDTH - 1) x1 = IMAGE_WIDTH - 1;
		if (y1 > IMAGE_HEIGHT - 1) y1 = IMAGE_HEIGHT - 1;
		for (longint py = y0; py <= y1; py++) begin
			for (longint px = x0; px <= x1; px++) begin
				cx = px * FX_ONE + FX_HALF;
				cy = py * FX_ONE + FX_HALF;
				e0 = edge_fn(a, b, cx, cy);
				e1 = edge_fn(b, c, cx, cy);
				e2 = edge_fn(c, a, cx, cy);
				if ((e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 <= 0 && e1 <= 0 && e2 <= 0))
					plot(px, py, rgb);
			end
		end
	endfunction

	// corner offsets {dx,dy,dz}: right, left, top faces
	function automatic bit [2:0] corner_of(int f, int i);
		bit [2:0] tbl [3][4] = '{'{3'b100, 3'b110, 3'b111, 3'b101},
			'{3'b010, 3'b110, 3'b111, 3'b011}, '{3'b001, 3'b101, 3'b111, 3'b011}};
		return tbl[f][i];
	endfunction

	function automatic void paint_voxel(cmd_t c);
		longint x, y, z, k[3];
		vtx_t q[4];
		vtx_t mid;
		bit [2:0] d;
		x = c.voxel_x;
		y = c.voxel_y;
		z = c.voxel_z;
		k = '{SH_RIGHT, SH_LEFT, SH_TOP};
		mid = proj(2 * x + 1, 2 * y + 1, 2 * z + 1);
		last_col = int'(round_away(mid.x) & 255);
		last_row = int'(round_away(mid.y) & 255);
		if (scl * 5 < 6 * FX_ONE) begin
			plot(round_away(mid.x), round_away(mid.y),
				shade_rgb(c.red, c.green, c.blue, SH_SMALL));
			return;
		end
		for (int f = 0; f < 3; f++) begin
			for (int i = 0; i < 4; i++) begin
				d = corner_of(f, i);
				q[i] = proj(2 * (x + d[2]), 2 * (y + d[1]), 2 * (z + d[0]));
			end
			fill_triangle(q[0], q[1], q[2], shade_rgb(c.red, c.green, c.blue, k[f]));
			fill_triangle(q[0], q[2], q[3], shade_rgb(c.red, c.green, c.blue, k[f]));
		end
	endfunction

	function automatic reply_t apply_cmd(cmd_t c);
		reply_t r;
		bit [23:0] g;
		r = '0;
		r.reply_kind = c.action;
		case (c.action)
			ACT_CLEAR: begin
				n_clear++;
				for (int y = 0; y < IMAGE_HEIGHT; y++) begin
					g[23:16] = 8'((68 * (IMAGE_HEIGHT - 1) + 32 * y + (IMAGE_HEIGHT - 1))
						/ (2 * (IMAGE_HEIGHT - 1)));
					g[15:8] = g[23:16] + 8'd2;
					g[7:0] = g[23:16] + 8'd7;
					for (int x = 0; x < IMAGE_WIDTH; x++)
						pix_mem[y * IMAGE_WIDTH + x] = g;
				end
			end
			ACT_DRAW: begin
				n_draw++;
				paint_voxel(c);
			end
			ACT_READ: begin
				n_read++;
				{r.pixel_red, r.pixel_green, r.pixel_blue} =
					pix_mem[int'(c.pixel_row) * IMAGE_WIDTH + int'(c.pixel_column)];
			end
			default: n_other++;
		endcase
		return r;
	endfunction

	// checker: every strobe pairs with the oldest pending reply
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done) begin
			replies_seen++;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply %p", reply);
			end else begin
				want = pending_replies.pop_front();
				if (reply.reply_kind !== want.reply_kind || reply.pixel_red !== want.pixel_red
					|| reply.pixel_green !== want.pixel_green
					|| reply.pixel_blue !== want.pixel_blue) begin
					mismatches++;
					if (mismatches <= 10)
						$display("reply mismatch: expected %p, got %p", want, reply);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[voxel_cube_rasterizer] ERROR");
			$finish;
		end
	end

	task automatic send_word(cmd_t c, bit typed, reply_t r);
		reply_t p;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		p = apply_cmd(c);
		pending_replies.push_back(typed ? r : p);
	endtask

	task automatic quiesce();
		start <= 1'b0;
		wait (pending_replies.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_regs(longint s, longint ox, longint oy);
		logic [23:0] val [4];
		val = '{24'(s), 24'(ox), 24'(oy), 24'($urandom)};
		quiesce();
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		scl = s & 13'h1fff;
		offx = longint'($signed(24'(ox)));
		offy = longint'($signed(24'(oy)));
		n_phase++;
	endtask

	function automatic cmd_t random_word();
		cmd_t c;
		int pick;
		c = cmd_t'({$urandom, $urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick == 0)
			c.action = ACT_CLEAR;
		else if (pick < 4)
			c.action = ACT_NONE;
		else if (pick < 52)
			c.action = ACT_DRAW;
		else
			c.action = ACT_READ;
		if (c.action == ACT_DRAW && $urandom_range(0, 4) != 0) begin
			c.voxel_x = 12'($urandom_range(0, 15));
			c.voxel_y = 8'($urandom_range(0, 15));
			c.voxel_z = 8'($urandom_range(0, 15));
		end
		if (c.action == ACT_READ && $urandom_range(0, 3) != 0) begin
			c.pixel_column = 8'(last_col + $urandom_range(0, 30) - 15);
			c.pixel_row = 8'(last_row + $urandom_range(0, 30) - 15);
		end
		return c;
	endfunction

	task automatic run_random(int count, bit idle_on);
		for (int n = 0; n < count; n++) begin
			if (idle_on && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			send_word(random_word(), 1'b0, '0);
		end
	endtask

	initial begin
		row_t rows [$];
		row_t w;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// at reset scale 1.0: small-mode draws only
		w = '{c: '0, typed: 1'b1, r: '{ACT_CLEAR, 8'd0, 8'd0, 8'd0}};
		rows.push_back(w);
		w.c.action = ACT_READ; w.r = '{ACT_READ, 8'd34, 8'd36, 8'd41};
		rows.push_back(w);
		w.c.pixel_column = 8'd255; w.c.pixel_row = 8'd255; w.r = '{ACT_READ, 8'd50, 8'd52, 8'd57};
		rows.push_back(w);
		w.c.pixel_column = 8'd17; w.c.pixel_row = 8'd128; w.r = '{ACT_READ, 8'd42, 8'd44, 8'd49};
		rows.push_back(w);
		w.c = '1; w.r = '{ACT_NONE, 8'd0, 8'd0, 8'd0};
		rows.push_back(w);
		w.c = '0; w.c.action = ACT_DRAW; w.c.red = 8'hff; w.c.green = 8'hff; w.c.blue = 8'hff;
		w.r = '{ACT_DRAW, 8'd0, 8'd0, 8'd0};
		rows.push_back(w);
		w.c = '0; w.c.action = ACT_READ; w.r = '{ACT_READ, 8'd242, 8'd242, 8'd242};
		rows.push_back(w);
		w.typed = 1'b0;
		w.c = '{ACT_DRAW, 12'hfff, 8'hff, 8'hff, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00};
		rows.push_back(w);
		w.c = '{ACT_DRAW, 12'd5, 8'd0, 8'd0, 8'h01, 8'hfe, 8'h7f, 8'hff, 8'hff};
		rows.push_back(w);
		w.c = '{ACT_READ, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd4, 8'd2};
		rows.push_back(w);
		w.c = '{ACT_READ, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0};
		rows.push_back(w);
		foreach (rows[i])
			send_word(rows[i].c, rows[i].typed, rows[i].r);

		write_regs(6144, 128 << 8, 40 << 8);
		run_random(10, 1'b1);
		write_regs(307, 128 << 8, 100 << 8);
		run_random(30, 1'b1);
		write_regs(308, (128 << 8) + 77, (100 << 8) + 200);
		run_random(20, 1'b1);
		write_regs(0, (5 << 8) + 3, -3);
		run_random(15, 1'b1);
		for (int p = 0; p < 3; p++) begin
			write_regs($urandom_range(309, 2048), $urandom_range(100 << 8, 156 << 8),
				$urandom_range(60 << 8, 120 << 8));
			run_random(55, 1'b1);
		end
		write_regs(1024, 8388607, -8388608);
		run_random(12, 1'b1);
		write_regs(512, -8388608, 8388607);
		run_random(12, 1'b1);
		write_regs(1024, 128 << 8, 80 << 8);
		run_random(50, 1'b0);

		quiesce();
		repeat (40) @(posedge clk);
		if (pending_replies.size() != 0)
			mismatches++;
		$display("covered %0d clears, %0d draws, %0d reads, %0d unused actions over %0d settings",
			n_clear, n_draw, n_read, n_other, n_phase);
		$display("%0d replies checked, %0d mismatches, %0d cycles", replies_seen, mismatches,
			cycles);
		if (mismatches == 0)
			$display("[voxel_cube_rasterizer] OK");
		else
			$display("[voxel_cube_rasterizer] ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/vcr_pkg.sv
rtl/voxel_cube_rasterizer.sv
tb/voxel_cube_rasterizer_tb.sv
